@@ src/polygon_perimeter_defines.svh @@
// Assertion macros shared by the polygon perimeter RTL.
// Expects a clock named clk and a synchronous reset named rst in scope.
`ifndef POLYGON_PERIMETER_DEFINES_SVH
`define POLYGON_PERIMETER_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define PP_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define PP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/pp_pkg.sv @@
// Package for the polygon perimeter block: default widths, count limits and
// the command and status structs between controller and datapath. No dependencies.
package pp_pkg;

  localparam int COORD_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF   = 24;
  localparam int COUNT_WIDTH     = 8;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

  // Commands from the controller, at most one active per cycle besides the sel_first qualifier.
  typedef struct packed {
    logic load;       // take the input transfer
    logic diff;       // form coordinate magnitudes
    logic sel_first;  // diff against the first vertex instead of the previous
    logic mulx;       // square dx
    logic muly;       // square dy
    logic root_init;  // sum the squares and start the root
    logic root_step;  // one root digit
    logic acc;        // add the root to the running length
    logic emit;       // load the result register and clear the polygon state
  } pp_cmd_t;

  typedef struct packed {
    logic was_first;  // the loaded vertex opened a polygon
    logic last;       // the loaded vertex closes the polygon
    logic root_last;  // the current root step is the final one
    logic out_busy;   // a result is held and not yet taken
  } pp_status_t;

endpackage

@@ src/pp_ctrl.sv @@
// Controller of the polygon perimeter block: sequences each vertex through
// the datapath. Depends on pp_pkg and polygon_perimeter_defines.svh.
`include "polygon_perimeter_defines.svh"

module pp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pp_pkg::pp_status_t status,
  output pp_pkg::pp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_DIFF, S_MULX, S_MULY, S_SUMSQ, S_ROOT, S_ACC, S_OUT
  } state_t;

  state_t     state, state_next;
  logic       closing, closing_next;
  logic [7:0] cmd_pulses;

  assign cmd_pulses = {cmd.load, cmd.diff, cmd.mulx, cmd.muly,
                       cmd.root_init, cmd.root_step, cmd.acc, cmd.emit};

  always_comb begin
    state_next   = state;
    closing_next = closing;
    cmd          = '0;
    cmd.sel_first = closing;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        // A polygon's first vertex has no incoming segment.
        if (status.was_first) begin
          if (status.last) begin
            closing_next = 1'b1;
            state_next   = S_DIFF;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          state_next = S_DIFF;
        end
      end
      S_DIFF: begin
        cmd.diff   = 1'b1;
        state_next = S_MULX;
      end
      S_MULX: begin
        cmd.mulx   = 1'b1;
        state_next = S_MULY;
      end
      S_MULY: begin
        cmd.muly   = 1'b1;
        state_next = S_SUMSQ;
      end
      S_SUMSQ: begin
        cmd.root_init = 1'b1;
        state_next    = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (status.last && !closing) begin
          closing_next = 1'b1;
          state_next   = S_DIFF;
        end else if (status.last) begin
          state_next = S_OUT;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_OUT: begin
        if (!status.out_busy) begin
          cmd.emit     = 1'b1;
          closing_next = 1'b0;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next   = S_IDLE;
        closing_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      closing <= 1'b0;
    end else begin
      state   <= state_next;
      closing <= closing_next;
    end
  end

  `PP_ASSERT_ALWAYS(a_cmd_onehot, $onehot0(cmd_pulses), "more than one datapath command")
  `PP_ASSERT_IMPLIES(a_closing_last, closing, status.last, "closing on a vertex not marked last")
  `PP_ASSERT_IMPLIES(a_emit_closed, cmd.emit, closing, "result emitted before the closing segment")

endmodule

@@ src/pp_datapath.sv @@
// Datapath of the polygon perimeter block: vertex registers, squarer,
// bit-pair square root, saturating length sum and result register.
// Depends on pp_pkg and polygon_perimeter_defines.svh.
`include "polygon_perimeter_defines.svh"

module pp_datapath #(
  parameter int COORD_WIDTH = pp_pkg::COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = pp_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  pp_pkg::pp_cmd_t                cmd,
  output pp_pkg::pp_status_t             status,
  input  logic signed [COORD_WIDTH-1:0]  point_x,
  input  logic signed [COORD_WIDTH-1:0]  point_y,
  input  logic                           last_point,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SUM_WIDTH-1:0]           perimeter,
  output logic [pp_pkg::COUNT_WIDTH-1:0] vertex_count,
  output logic                           saturated
);

  localparam int ITER   = COORD_WIDTH + 1;           // root digits
  localparam int RAD_W  = 2 * ITER;                  // radicand width
  localparam int REM_W  = ITER + 1;                  // partial remainder width
  localparam int SQ_W   = 2 * COORD_WIDTH;
  localparam int ACC_W  = ((SUM_WIDTH > ITER) ? SUM_WIDTH : ITER) + 1;
  localparam int ITER_W = $clog2(ITER);
  localparam logic [SUM_WIDTH-1:0] SUM_MAX = {SUM_WIDTH{1'b1}};

  logic signed [COORD_WIDTH-1:0] cur_x, cur_y, first_x, first_y, prev_x, prev_y;
  logic                          last_r, was_first;
  logic [COORD_WIDTH-1:0]        dx, dy;
  logic [SQ_W-1:0]               sq_x, sq_y;
  logic [RAD_W-1:0]              rad;
  logic [REM_W-1:0]              rem;
  logic [ITER-1:0]               root;
  logic [ITER_W-1:0]             iter;
  logic [SUM_WIDTH-1:0]          length_sum;
  logic [pp_pkg::COUNT_WIDTH-1:0] count;
  logic                          sum_saturated;

  logic signed [COORD_WIDTH-1:0] ref_x, ref_y;
  logic signed [COORD_WIDTH:0]   diff_x, diff_y;
  logic [REM_W+1:0]              rem_w, trial;
  logic                          take;
  logic [ACC_W-1:0]              total;

  // Magnitudes of the coordinate differences fit the coordinate width.
  assign ref_x  = cmd.sel_first ? first_x : prev_x;
  assign ref_y  = cmd.sel_first ? first_y : prev_y;
  assign diff_x = {cur_x[COORD_WIDTH-1], cur_x} - {ref_x[COORD_WIDTH-1], ref_x};
  assign diff_y = {cur_y[COORD_WIDTH-1], cur_y} - {ref_y[COORD_WIDTH-1], ref_y};

  // One restoring root digit: bring down two radicand bits, try 4*root+1.
  assign rem_w = {rem, rad[RAD_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};
  assign take  = (rem_w >= trial);

  assign total = ACC_W'(length_sum) + ACC_W'(root);

  assign status.was_first = was_first;
  assign status.last      = last_r;
  assign status.root_last = (iter == '0);
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      first_x       <= '0;
      first_y       <= '0;
      prev_x        <= '0;
      prev_y        <= '0;
      length_sum    <= '0;
      count         <= '0;
      sum_saturated <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.load) begin
        if (count == '0) begin
          first_x       <= point_x;
          first_y       <= point_y;
          prev_x        <= point_x;
          prev_y        <= point_y;
          length_sum    <= '0;
          sum_saturated <= 1'b0;
        end
        if (count != pp_pkg::COUNT_MAX) begin
          count <= count + 1'b1;
        end
      end
      if (cmd.diff && !cmd.sel_first) begin
        prev_x <= cur_x;
        prev_y <= cur_y;
      end
      if (cmd.acc) begin
        if (total > ACC_W'(SUM_MAX)) begin
          length_sum    <= SUM_MAX;
          sum_saturated <= 1'b1;
        end else begin
          length_sum <= total[SUM_WIDTH-1:0];
        end
      end
      if (cmd.emit) begin
        out_valid     <= 1'b1;
        first_x       <= '0;
        first_y       <= '0;
        prev_x        <= '0;
        prev_y        <= '0;
        length_sum    <= '0;
        count         <= '0;
        sum_saturated <= 1'b0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x     <= point_x;
      cur_y     <= point_y;
      last_r    <= last_point;
      was_first <= (count == '0);
    end
    if (cmd.diff) begin
      dx <= diff_x[COORD_WIDTH] ? COORD_WIDTH'(-diff_x) : diff_x[COORD_WIDTH-1:0];
      dy <= diff_y[COORD_WIDTH] ? COORD_WIDTH'(-diff_y) : diff_y[COORD_WIDTH-1:0];
    end
    if (cmd.mulx) begin
      sq_x <= SQ_W'(dx) * SQ_W'(dx);
    end
    if (cmd.muly) begin
      sq_y <= SQ_W'(dy) * SQ_W'(dy);
    end
    if (cmd.root_init) begin
      rad  <= RAD_W'(sq_x) + RAD_W'(sq_y);
      rem  <= '0;
      root <= '0;
      iter <= ITER_W'(ITER - 1);
    end else if (cmd.root_step) begin
      rad  <= {rad[RAD_W-3:0], 2'b00};
      rem  <= take ? REM_W'(rem_w - trial) : REM_W'(rem_w);
      root <= {root[ITER-2:0], take};
      iter <= iter - 1'b1;
    end
    if (cmd.emit) begin
      perimeter    <= length_sum;
      vertex_count <= count;
      saturated    <= sum_saturated;
    end
  end

  `PP_ASSERT_IMPLIES(a_emit_free, cmd.emit, !status.out_busy, "result overwritten before transfer")
  `PP_ASSERT_IMPLIES(a_sat_max, sum_saturated, length_sum == SUM_MAX, "flag set below the ceiling")
  `PP_ASSERT_NEXT(a_emit_clear, cmd.emit, count == '0 && length_sum == '0, "state not cleared")

endmodule

@@ src/polygon_perimeter.sv @@
// Top level of the polygon perimeter block: controller plus datapath.
// Depends on pp_pkg, pp_ctrl and pp_datapath.
//
// Usage: vertices arrive on the input channel (in_valid/in_ready) as signed
// fixed-point point_x/point_y with 8 fractional bits; last_point marks the
// final vertex of a polygon. One result per polygon leaves on the output
// channel (out_valid/out_ready): perimeter (saturating), vertex_count
// (saturating at 255) and the saturated flag.
// Each vertex after the first costs one segment: difference, squaring of dx and
// of dy, radicand setup, one square-root step per root digit and an add, and
// in_ready stays low until that segment is done. The shared bit-pair square-root
// unit takes the largest part of it. The first vertex of a polygon that is not
// also its last holds in_ready low for one cycle only. The last vertex runs the
// closing segment as well; the result register is then loaded once it is free,
// and the result is valid in the cycle after that load.
// The result sits in an output register, so the next polygon's vertices are
// taken while it waits. If the receiver stalls while a second result is
// ready, the block holds that result internally and in_ready stays low.
// Reset (rst, synchronous) clears the polygon state, drops out_valid and holds in_ready low.
module polygon_perimeter #(
  parameter int COORD_WIDTH = pp_pkg::COORD_WIDTH_DEF,
  parameter int SUM_WIDTH   = pp_pkg::SUM_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [COORD_WIDTH-1:0]  point_x,
  input  logic signed [COORD_WIDTH-1:0]  point_y,
  input  logic                           last_point,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [SUM_WIDTH-1:0]           perimeter,
  output logic [pp_pkg::COUNT_WIDTH-1:0] vertex_count,
  output logic                           saturated
);

  // Commands flow from the controller, status back from the datapath.
  pp_pkg::pp_cmd_t    cmd;
  pp_pkg::pp_status_t status;

  pp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pp_datapath #(
    .COORD_WIDTH (COORD_WIDTH),
    .SUM_WIDTH   (SUM_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .perimeter    (perimeter),
    .vertex_count (vertex_count),
    .saturated    (saturated)
  );

endmodule

@@ sim/polygon_perimeter_tb.sv @@
// Self-checking bench for polygon_perimeter: drives vertex transfers, predicts each closed
// polygon's perimeter, vertex count and ceiling flag, and checks every result transfer.
// Depends on pp_pkg and the polygon_perimeter RTL only.
`timescale 1ns / 1ps

module polygon_perimeter_tb;

  localparam int CW = pp_pkg::COORD_WIDTH_DEF;
  localparam int SW = pp_pkg::SUM_WIDTH_DEF;
  localparam int NW = pp_pkg::COUNT_WIDTH;

  // Corner coordinates; long polygons that bounce between them reach the sum ceiling.
  localparam logic signed [CW-1:0] C_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] C_MIN = {1'b1, {(CW-1){1'b0}}};

  localparam int PHASE_ITEMS = 317;   // roughly a third of the vertex stream per phase
  localparam int HOLD_CYCLES = 600;   // long receiver stall that backs the block up
  localparam int STALL_LIMIT = 6000;  // cycles without any transfer before giving up
  localparam int DRAIN_CYCLES = 80;   // longer than the closing vertex takes

  // The prediction side. It keeps its own copy of the polygon state and a queue of
  // results that closed polygons are still owed.
  class perimeter_tracker;
    typedef struct {
      logic [SW-1:0] perimeter;
      logic [NW-1:0] vcount;
      logic          sat;
    } closed_poly_t;

    closed_poly_t owed[$];
    longint first_x, first_y, prev_x, prev_y;
    longint unsigned run_len;
    int unsigned nverts;
    bit ceiling_hit;
    int mismatches, checked, sat_results, max_count;

    function new();
      clear();
      mismatches = 0;
      checked = 0;
      sat_results = 0;
      max_count = 0;
    endfunction

    function void clear();
      first_x = 0;
      first_y = 0;
      prev_x = 0;
      prev_y = 0;
      run_len = 0;
      nverts = 0;
      ceiling_hit = 0;
    endfunction

    // Truncated Euclidean length of one edge, one root bit per bit pair of the radicand.
    function longint unsigned edge_len(longint ax, longint ay, longint bx, longint by);
      longint dx, dy;
      longint unsigned rad, rem, root, trial;
      dx = ax - bx;
      dy = ay - by;
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      rad = dx * dx + dy * dy;
      rem = 0;
      root = 0;
      for (int i = CW; i >= 0; i--) begin
        rem = (rem << 2) | ((rad >> (2 * i)) & 64'd3);
        root = root << 1;
        trial = (root << 1) | 64'd1;
        if (rem >= trial) begin
          rem = rem - trial;
          root = root | 64'd1;
        end
      end
      return root;
    endfunction

    // The running length sticks at its top value and remembers that it did.
    function void add_len(longint unsigned d);
      longint unsigned s, top;
      top = (64'd1 << SW) - 1;
      s = run_len + d;
      if (s > top) begin
        s = top;
        ceiling_hit = 1;
      end
      run_len = s;
    endfunction

    function void note_vertex(logic signed [CW-1:0] px, logic signed [CW-1:0] py, logic last);
      longint x, y;
      closed_poly_t r;
      x = px;
      y = py;
      if (nverts == 0) begin
        first_x = x;
        first_y = y;
        run_len = 0;
        ceiling_hit = 0;
      end else begin
        add_len(edge_len(x, y, prev_x, prev_y));
      end
      prev_x = x;
      prev_y = y;
      if (nverts < pp_pkg::COUNT_MAX) nverts++;
      if (last) begin
        // The closing edge back to the first vertex; zero for a lone point.
        add_len(edge_len(x, y, first_x, first_y));
        r.perimeter = run_len[SW-1:0];
        r.vcount = nverts[NW-1:0];
        r.sat = ceiling_hit;
        owed.push_back(r);
        clear();
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [SW-1:0] perim, logic [NW-1:0] cnt, logic sat);
      closed_poly_t want;
      if (owed.size() == 0) begin
        flag($sformatf("result with no polygon closed: perimeter %0d count %0d sat %0b",
                       perim, cnt, sat));
        return;
      end
      want = owed.pop_front();
      checked++;
      if (sat) sat_results++;
      if (cnt > max_count) max_count = cnt;
      if (perim !== want.perimeter || cnt !== want.vcount || sat !== want.sat)
        flag($sformatf("polygon %0d: expected perimeter %0d count %0d sat %0b, got %0d %0d %0b",
                       checked, want.perimeter, want.vcount, want.sat, perim, cnt, sat));
    endfunction

    function int pending();
      return owed.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   in_valid;
  logic                   in_ready;
  logic signed [CW-1:0]   point_x;
  logic signed [CW-1:0]   point_y;
  logic                   last_point;
  logic                   out_valid;
  logic                   out_ready;
  logic [SW-1:0]          perimeter;
  logic [NW-1:0]          vertex_count;
  logic                   saturated;

  perimeter_tracker tracker = new();

  int phase = 0;           // 0: receiver sparse, 1: sender sparse, 2: both flat out
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int n_sent = 0;
  int quiet_cycles = 0;

  polygon_perimeter u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .perimeter    (perimeter),
    .vertex_count (vertex_count),
    .saturated    (saturated)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Every transfer is observed at the rising edge, on the values that were settled
  // before it. The same block keeps the watchdog: it counts edges with no transfer on
  // either side and ends the run if the block appears stuck.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_vertex(point_x, point_y, last_point);
      if (out_valid && out_ready) tracker.check_result(perimeter, vertex_count, saturated);
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("no transfer for %0d cycles, %0d results still owed",
                 quiet_cycles, tracker.pending());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Receiver. On entering the last phase it refuses results for a long stretch while
  // the sender keeps going, so the output register and the internal holding slot both
  // fill and the block has to drop in_ready. Otherwise it stalls at the phase's rate.
  initial begin
    int hold_left;
    bit held;
    hold_left = 0;
    held = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!held && phase == 2) begin
        held = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offers one vertex. Entered and left at a falling edge. A gap, if any, drops valid
  // first; otherwise valid stays high straight into the next transfer.
  task automatic send_vertex(input logic signed [CW-1:0] x, input logic signed [CW-1:0] y,
                             input logic last);
    int gap;
    gap = 0;
    while (send_idle_pct > 0 && gap < 12 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    point_x    <= x;
    point_y    <= y;
    last_point <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  // Mostly full-range values, with a share of small ones near the origin and of corners.
  function automatic logic signed [CW-1:0] pick_coord();
    int sel;
    sel = $urandom_range(0, 7);
    case (sel)
      0: return $urandom_range(0, 1) ? C_MAX : C_MIN;
      1, 2: return CW'($urandom_range(0, 1023) - 512);
      default: return CW'($urandom);
    endcase
  endfunction

  // A whole polygon. The corner-hopping kind alternates near opposite corners so that
  // each edge is close to the longest possible and the length sum runs into its ceiling.
  task automatic send_polygon(input int len, input bit corner_hop);
    logic signed [CW-1:0] x, y;
    for (int i = 0; i < len; i++) begin
      if (corner_hop) begin
        x = (i % 2) ? C_MAX - CW'($urandom_range(0, 15)) : C_MIN + CW'($urandom_range(0, 15));
        y = (i % 2) ? C_MAX - CW'($urandom_range(0, 15)) : C_MIN + CW'($urandom_range(0, 15));
      end else begin
        x = pick_coord();
        y = pick_coord();
      end
      send_vertex(x, y, i == len - 1);
    end
  endtask

  // Hand-picked polygons: lone points, two-vertex polygons whose one edge counts twice,
  // exact and truncated roots, and the coordinate extremes.
  task automatic send_directed();
    send_vertex('0, '0, 1'b1);
    send_vertex(C_MIN, C_MAX, 1'b1);
    send_vertex(C_MIN, C_MIN, 1'b0);
    send_vertex(C_MAX, C_MAX, 1'b1);
    send_vertex(C_MAX, C_MIN, 1'b0);
    send_vertex(C_MIN, C_MAX, 1'b1);
    send_vertex(C_MAX, '0, 1'b0);
    send_vertex(C_MIN, '0, 1'b1);
    // A 3-4-5 triangle in whole units.
    send_vertex('0, '0, 1'b0);
    send_vertex(CW'(768), '0, 1'b0);
    send_vertex('0, CW'(1024), 1'b1);
    // A square one LSB on a side.
    send_vertex('0, '0, 1'b0);
    send_vertex(CW'(1), '0, 1'b0);
    send_vertex(CW'(1), CW'(1), 1'b0);
    send_vertex('0, CW'(1), 1'b1);
    // The diagonal of one LSB truncates to one.
    send_vertex('0, '0, 1'b0);
    send_vertex(CW'(1), CW'(1), 1'b1);
    send_vertex(CW'(-1), CW'(-1), 1'b0);
    send_vertex(CW'(16'h5555), CW'(16'hAAAA), 1'b1);
  endtask

  initial begin
    int len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    point_x    = '0;
    point_y    = '0;
    last_point = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      phase = ph;
      send_idle_pct = (ph == 0) ? 38 : (ph == 1) ? 60 : 0;
      recv_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 38 : 0;
      if (ph == 0) send_directed();
      // Phase 0 hits the length ceiling with the count still below its limit;
      // phase 1 runs past the count limit as well.
      if (ph == 0) send_polygon($urandom_range(190, 250), 1'b1);
      if (ph == 1) send_polygon($urandom_range(256, 300), 1'b1);
      while (n_sent < (ph + 1) * PHASE_ITEMS) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        send_polygon(len, 1'b0);
      end
    end
    in_valid <= 1'b0;

    // Let the owed results drain; the watchdog covers a block that never delivers.
    while (tracker.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Ran %0d vertices as %0d closed polygons through sparse, reversed and full-rate",
             n_sent, tracker.checked);
    $display("handshakes; %0d results reached the length ceiling, top vertex count %0d.",
             tracker.sat_results, tracker.max_count);
    if (tracker.mismatches == 0 && tracker.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results never arrived", tracker.mismatches,
               tracker.pending());
      $display("FAILURE");
    end
    $finish;
  end

endmodule
